// ----- rtl/core/json_string_escaper_core_defines.svh -----
// Assertion macros shared by the JSON string escaper RTL.
// Depends on nothing; the including module supplies clk and arst_n.
`ifndef JSON_STRING_ESCAPER_CORE_DEFINES_SVH
`define JSON_STRING_ESCAPER_CORE_DEFINES_SVH

// Check that a condition implies another in the same cycle
`define JSE_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that a condition implies another in the next cycle
`define JSE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/core/jse_pkg.sv -----
// Package for the JSON string escaper: constants, result struct, hex helper.
// Depends on nothing.
package jse_pkg;

	localparam int unsigned CAP_W = 13;
	localparam int unsigned CNT_W = 12;
	localparam int unsigned IDX_W = 3;

	localparam logic [CAP_W-1:0] CAP_LIMIT = 13'd4096;
	localparam logic [CAP_W-1:0] CAP_RESET = 13'd128;
	localparam logic [7:0]       CTRL_LIMIT = 8'h20;

	// Character codes used by the escape sequences
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_BS    = 8'h08;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_FF    = 8'h0C;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_BSL   = 8'h5C;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LB    = 8'h62;
	localparam logic [7:0] CH_LF_N  = 8'h66;
	localparam logic [7:0] CH_LN    = 8'h6E;
	localparam logic [7:0] CH_LR    = 8'h72;
	localparam logic [7:0] CH_LT    = 8'h74;
	localparam logic [7:0] CH_LU    = 8'h75;

	// Positions in the escape forms: first byte, pair end, high hex digit, hex end
	localparam logic [IDX_W-1:0] IDX_FIRST    = 3'd0;
	localparam logic [IDX_W-1:0] IDX_PAIR_END = 3'd1;
	localparam logic [IDX_W-1:0] IDX_HEX_HI   = 3'd4;
	localparam logic [IDX_W-1:0] IDX_HEX_END  = 3'd5;

	// One result byte as it travels to the output register
	typedef struct packed {
		logic [7:0]       out_byte;
		logic             last_in_run;
		logic             end_of_string;
		logic [CNT_W-1:0] written_count;
	} jse_res_t;

	// Escape decision for the byte under work
	typedef struct packed {
		logic       emit;
		logic [7:0] out_byte;
		logic       last;
		logic       eos;
	} jse_esc_t;

	// Lower-case hex digit of a nibble
	function automatic logic [7:0] hex_lower(input logic [3:0] v);
		logic [7:0] r;
		if (v < 4'd10) begin
			r = CH_ZERO + {4'b0, v};
		end else begin
			r = CH_LA + {4'b0, v} - 8'd10;
		end
		return r;
	endfunction

endpackage

// ----- rtl/core/jse_escape.sv -----
// Escape selector: picks the result byte for the held source byte and position.
// Depends on jse_pkg.
module jse_escape import jse_pkg::*; (
	input  logic [7:0]       src_byte,
	input  logic [IDX_W-1:0] idx,
	input  logic [CNT_W-1:0] base_count,
	input  logic [CAP_W-1:0] cap,
	output jse_esc_t         esc
);

	logic [CAP_W-1:0] base_ext;
	logic             full;
	logic             hex_room;
	logic             pair;
	logic [7:0]       pair_char;

	// Room checks against the count at the start of this item
	assign base_ext = {1'b0, base_count};
	assign full     = (base_ext + 13'd2) >= cap;
	assign hex_room = (base_ext + 13'd6) < cap;

	// Map the two-byte escapes to their second character
	always_comb begin
		pair      = 1'b1;
		pair_char = src_byte;
		case (src_byte)
			CH_QUOTE: pair_char = CH_QUOTE;
			CH_BSL:   pair_char = CH_BSL;
			CH_BS:    pair_char = CH_LB;
			CH_FF:    pair_char = CH_LF_N;
			CH_LF:    pair_char = CH_LN;
			CH_CR:    pair_char = CH_LR;
			CH_TAB:   pair_char = CH_LT;
			default:  pair = 1'b0;
		endcase
	end

	// Select the byte at this position of the escape sequence
	always_comb begin
		esc = '{emit: 1'b0, out_byte: CH_NUL, last: 1'b0, eos: 1'b0};
		if (src_byte == CH_NUL) begin
			esc = '{emit: 1'b1, out_byte: CH_NUL, last: 1'b1, eos: 1'b1};
		end else if (full) begin
			esc.emit = 1'b0;
		end else if (pair) begin
			esc.emit     = 1'b1;
			esc.out_byte = (idx == IDX_FIRST) ? CH_BSL : pair_char;
			esc.last     = (idx == IDX_PAIR_END);
		end else if (src_byte < CTRL_LIMIT) begin
			if (hex_room) begin
				esc.emit = 1'b1;
				esc.last = (idx == IDX_HEX_END);
				case (idx)
					3'd0:       esc.out_byte = CH_BSL;
					3'd1:       esc.out_byte = CH_LU;
					3'd2:       esc.out_byte = CH_ZERO;
					3'd3:       esc.out_byte = CH_ZERO;
					IDX_HEX_HI: esc.out_byte = hex_lower(src_byte[7:4]);
					default:    esc.out_byte = hex_lower(src_byte[3:0]);
				endcase
			end
		end else begin
			esc.emit     = 1'b1;
			esc.out_byte = src_byte;
			esc.last     = 1'b1;
		end
	end

endmodule

// ----- rtl/core/jse_out_reg.sv -----
// Output register: holds one result item until the consumer takes it.
// Depends on jse_pkg.
module jse_out_reg import jse_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  jse_res_t         res,
	output logic             room,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [7:0]       out_byte,
	output logic             last_in_run,
	output logic             end_of_string,
	output logic [CNT_W-1:0] written_count
);

	logic     valid_q;
	jse_res_t res_q;

	// Accept a new result when empty or when the held one leaves now
	assign room = !valid_q || out_ready;

	// Track occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (room) begin
			valid_q <= load;
		end
	end

	// Capture payload
	always_ff @(posedge clk) begin
		if (load && room) begin
			res_q <= res;
		end
	end

	assign out_valid     = valid_q;
	assign out_byte      = res_q.out_byte;
	assign last_in_run   = res_q.last_in_run;
	assign end_of_string = res_q.end_of_string;
	assign written_count = res_q.written_count;

endmodule

// ----- rtl/core/json_string_escaper_core.sv -----
// JSON string escaper top level: input stage, escape sequencer, write count.
// An accepted byte waits in the input stage; its results pass the output register.
// Throughput: one result per cycle while out_ready holds; a byte stays held until
// it has made all its result bytes (one to six), and a skipped byte makes none.
// Reset: arst_n clears the count and all valid flags; capacity returns to 128.
// Depends on jse_pkg, jse_escape, jse_out_reg and the assertion macro header.
`include "json_string_escaper_core_defines.svh"
module json_string_escaper_core import jse_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [CAP_W-1:0] cfg_wdata,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [7:0]       byte_in,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [7:0]       out_byte,
	output logic             last_in_run,
	output logic             end_of_string,
	output logic [CNT_W-1:0] written_count
);

	logic [CAP_W-1:0] out_capacity_q;
	logic [CAP_W-1:0] cap;
	logic             valid_s1;
	logic [7:0]       byte_s1;
	logic [IDX_W-1:0] idx_q;
	logic [CNT_W-1:0] write_count_q;
	logic [CNT_W-1:0] base_count;
	jse_esc_t         esc;
	jse_res_t         res;
	logic             room;
	logic             load;
	logic             release_s1;

	// Capacity register, clamped to the largest buffer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_capacity_q <= CAP_RESET;
		end else if (cfg_we) begin
			out_capacity_q <= cfg_wdata;
		end
	end
	assign cap = (out_capacity_q > CAP_LIMIT) ? CAP_LIMIT : out_capacity_q;

	// Count at the start of the held item
	assign base_count = write_count_q - {{(CNT_W-IDX_W){1'b0}}, idx_q};

	jse_escape u_escape (
		.src_byte   (byte_s1),
		.idx        (idx_q),
		.base_count (base_count),
		.cap        (cap),
		.esc        (esc)
	);

	// Build the result item
	always_comb begin
		res.out_byte      = esc.out_byte;
		res.last_in_run   = esc.last;
		res.end_of_string = esc.eos;
		res.written_count = esc.eos ? write_count_q : write_count_q + 12'd1;
	end

	assign load       = valid_s1 && esc.emit && room;
	assign release_s1 = valid_s1 && (!esc.emit || (room && esc.last));
	assign in_ready   = !valid_s1 || release_s1;

	// Input stage: hold the source byte until its last result goes out or it is skipped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= byte_in;
		end
	end

	// Advance the sequence position and the write count per result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q         <= IDX_FIRST;
			write_count_q <= '0;
		end else if (load) begin
			idx_q         <= esc.last ? IDX_FIRST : idx_q + 3'd1;
			write_count_q <= esc.eos ? '0 : write_count_q + 12'd1;
		end
	end

	jse_out_reg u_out_reg (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (load),
		.res           (res),
		.room          (room),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.out_byte      (out_byte),
		.last_in_run   (last_in_run),
		.end_of_string (end_of_string),
		.written_count (written_count)
	);

	// Checks on the sequencer and count
	`JSE_ASSERT_NEXT(a_eos_clears, load && esc.eos, write_count_q == '0, "count not cleared")
	`JSE_ASSERT_NEXT(a_release_idx, release_s1, idx_q == IDX_FIRST, "position not rewound")
	`JSE_ASSERT_SAME(a_eos_first, load && esc.eos, idx_q == IDX_FIRST && esc.last, "bad end")
	`JSE_ASSERT_SAME(a_data_nonzero, out_valid && !end_of_string,
		out_byte != CH_NUL && written_count != '0, "zero data result")
	`JSE_ASSERT_SAME(a_idx_range, valid_s1, idx_q <= IDX_HEX_END, "position out of range")

endmodule
